// ===== rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// shared sizes, token class codes and name table port types for the lexer
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int NAME_MAX    = 64;

  localparam int CNT_W    = $clog2(NAME_MAX + 1);
  localparam int POS_W    = $clog2(NAME_MAX);
  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int EC_W     = $clog2(TABLE_DEPTH + 1);
  localparam int NS_DEPTH = TABLE_DEPTH * NAME_MAX;
  localparam int NS_AW    = $clog2(NS_DEPTH);
  localparam int ADDR_W   = 17;

  // token classes
  localparam logic [3:0] CLS_STRING  = 4'd0;
  localparam logic [3:0] CLS_KEYWORD = 4'd1;
  localparam logic [3:0] CLS_FUNC    = 4'd2;
  localparam logic [3:0] CLS_MAIN    = 4'd3;
  localparam logic [3:0] CLS_IDENT   = 4'd4;
  localparam logic [3:0] CLS_INT     = 4'd5;
  localparam logic [3:0] CLS_ARITH   = 4'd6;
  localparam logic [3:0] CLS_ARITH_A = 4'd7;
  localparam logic [3:0] CLS_LOGIC   = 4'd8;
  localparam logic [3:0] CLS_REL     = 4'd9;
  localparam logic [3:0] CLS_ASSIGN  = 4'd10;
  localparam logic [3:0] CLS_SPECIAL = 4'd11;

  // configuration register indexes
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_EBYTE = 1'b1;

  typedef struct packed {
    logic              ent_we;
    logic              byte_we;
    logic [IDX_W-1:0]  widx;
    logic [POS_W-1:0]  wpos;
    logic [7:0]        wbyte;
    logic [CNT_W-1:0]  wlen;
    logic [ADDR_W-1:0] waddr;
    logic [IDX_W-1:0]  ridx;
    logic [POS_W-1:0]  rpos;
  } tbl_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        name_byte;
  } tbl_rsp_t;

endpackage

// ===== rtl/slt_ifs.sv =====
// ----------------------------------------------------------------------------
// slt_ifs
// valid/ready channels for source characters and token results
// ----------------------------------------------------------------------------
interface slt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;
  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface slt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_class;
  logic [7:0]  first_char;
  logic [6:0]  token_length;
  logic [6:0]  symbol_index;
  logic [16:0] symbol_address;
  logic        is_new_symbol;
  logic        table_full;
  logic        name_truncated;
  logic        last_of_run;
  modport source (output valid, token_class, first_char, token_length, symbol_index,
                  symbol_address, is_new_symbol, table_full, name_truncated,
                  last_of_run, input ready);
  modport sink   (input valid, token_class, first_char, token_length, symbol_index,
                  symbol_address, is_new_symbol, table_full, name_truncated,
                  last_of_run, output ready);
endinterface

// ===== rtl/slt_tok_buf.sv =====
// ----------------------------------------------------------------------------
// slt_tok_buf
// text of the open token, one write and one registered read port
// ----------------------------------------------------------------------------
module slt_tok_buf (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [slt_pkg::POS_W-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic [slt_pkg::POS_W-1:0] raddr_i,
  output logic [7:0]                rdata_o
);

  logic [7:0] mem [slt_pkg::NAME_MAX];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/slt_name_tbl.sv =====
// ----------------------------------------------------------------------------
// slt_name_tbl
// identifier table: name bytes, name lengths and entry addresses
// ----------------------------------------------------------------------------
module slt_name_tbl (
  input  logic              clk_i,
  input  slt_pkg::tbl_req_t req_i,
  output slt_pkg::tbl_rsp_t rsp_o
);

  logic [7:0]                 name_mem [slt_pkg::NS_DEPTH];
  logic [slt_pkg::CNT_W-1:0]  len_mem  [slt_pkg::TABLE_DEPTH];
  logic [slt_pkg::ADDR_W-1:0] addr_mem [slt_pkg::TABLE_DEPTH];
  logic [slt_pkg::NS_AW-1:0]  wa;
  logic [slt_pkg::NS_AW-1:0]  ra;
  slt_pkg::tbl_rsp_t          rsp_q;

  // row base times a constant row size
  assign wa = slt_pkg::NS_AW'(req_i.widx * slt_pkg::NAME_MAX) + slt_pkg::NS_AW'(req_i.wpos);
  assign ra = slt_pkg::NS_AW'(req_i.ridx * slt_pkg::NAME_MAX) + slt_pkg::NS_AW'(req_i.rpos);

  always_ff @(posedge clk_i) begin
    if (req_i.byte_we) begin
      name_mem[wa] <= req_i.wbyte;
    end
    if (req_i.ent_we) begin
      len_mem[req_i.widx]  <= req_i.wlen;
      addr_mem[req_i.widx] <= req_i.waddr;
    end
    rsp_q.name_byte <= name_mem[ra];
    rsp_q.len       <= len_mem[req_i.ridx];
    rsp_q.addr      <= addr_mem[req_i.ridx];
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/c_subset_lexer_symbol_table.sv =====
// ----------------------------------------------------------------------------
// c_subset_lexer_symbol_table
// character stream lexer for a small c subset with an identifier table
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_i      in   valid/ready   char_code, end_of_text
//  out_o     out  valid/ready   token_class .. last_of_run (one token item)
//  cfg       in   cfg_we_i      cfg_idx_i, cfg_wdata_i (write only)
//
//  a character passes the scan sequencer states idle, mode, start where a token
//  may begin, end-of-text check and finish; an identifier end walks the name
//  table with one shared byte comparator, reading and checking each entry's
//  length, then its name bytes one by one; a new name is copied byte by byte
//  results sit in a holding register and an output register; the sequencer
//  waits whenever both are full and out_o is stalled
//  reset is asynchronous; no clearing pass, the tables are read only where
//  already written
// ----------------------------------------------------------------------------
module c_subset_lexer_symbol_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  slt_in_if.sink           in_i,
  slt_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i
);

  localparam int CNT_W  = slt_pkg::CNT_W;
  localparam int POS_W  = slt_pkg::POS_W;
  localparam int IDX_W  = slt_pkg::IDX_W;
  localparam int EC_W   = slt_pkg::EC_W;
  localparam int ADDR_W = slt_pkg::ADDR_W;
  localparam int KW_N   = 6;

  // scan modes
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_WORD = 3'd1;
  localparam logic [2:0] M_NUM  = 3'd2;
  localparam logic [2:0] M_STR  = 3'd3;
  localparam logic [2:0] M_OP   = 3'd4;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MODE  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_EOT   = 4'd3;
  localparam logic [3:0] S_FIN   = 4'd4;
  localparam logic [3:0] S_KW    = 4'd5;
  localparam logic [3:0] S_LENRD = 4'd6;
  localparam logic [3:0] S_LENCK = 4'd7;
  localparam logic [3:0] S_BRD   = 4'd8;
  localparam logic [3:0] S_BCK   = 4'd9;
  localparam logic [3:0] S_NEW   = 4'd10;
  localparam logic [3:0] S_CRD   = 4'd11;
  localparam logic [3:0] S_CWR   = 4'd12;
  localparam logic [3:0] S_NEMIT = 4'd13;

  typedef struct packed {
    logic [3:0]  cls;
    logic [7:0]  fc;
    logic [6:0]  len;
    logic [6:0]  idx;
    logic [16:0] addr;
    logic        is_new;
    logic        full;
    logic        trunc;
    logic        last;
  } res_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_arith(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%";
  endfunction

  function automatic logic is_opch(input logic [7:0] c);
    return is_arith(c) || c == "&" || c == "|" || c == "!" || c == "=" ||
           c == "<" || c == ">";
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return c == ";" || c == "," || c == "." || c == "[" || c == "]" ||
           c == "(" || c == ")" || c == "{" || c == "}";
  endfunction

  // compare the open word with a left-aligned constant of slen bytes
  function automatic logic word_is(input logic [7:0] kb [KW_N], input logic [CNT_W-1:0] cnt,
                                   input logic over, input logic [8*KW_N-1:0] s,
                                   input int slen);
    logic ok;
    ok = !over && (cnt == CNT_W'(slen));
    for (int k = 0; k < KW_N; k++) begin
      if (k < slen && kb[k] != s[8*KW_N-1-8*k -: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic res_t mk(input logic [3:0] cls, input logic [7:0] fc,
                              input logic [6:0] len, input logic [6:0] idx,
                              input logic [16:0] addr, input logic nw,
                              input logic full, input logic trunc);
    res_t r;
    r.cls    = cls;
    r.fc     = fc;
    r.len    = len;
    r.idx    = idx;
    r.addr   = addr;
    r.is_new = nw;
    r.full   = full;
    r.trunc  = trunc;
    r.last   = 1'b0;
    return r;
  endfunction

  // state
  logic [3:0]        state_q, state_d;
  logic [2:0]        mode_q, mode_d;
  logic [7:0]        c_q, c_d;
  logic              eot_q, eot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              over_q, over_d;
  logic [7:0]        first_q, first_d;
  logic [7:0]        kb_q [KW_N];
  logic [7:0]        kb_d [KW_N];
  logic [7:0]        pop_q, pop_d;
  logic [EC_W-1:0]   ec_q, ec_d;
  logic [ADDR_W-1:0] nxt_q, nxt_d;
  logic [15:0]       base_q, base_d;
  logic [4:0]        eb_q, eb_d;
  logic [IDX_W-1:0]  i_q, i_d;
  logic [POS_W-1:0]  j_q, j_d;
  logic              hasnext_q, hasnext_d;
  logic              retfin_q, retfin_d;
  res_t              pend_q, pend_d;
  logic              pend_v_q, pend_v_d;
  res_t              out_q, out_d;
  logic              out_v_q, out_v_d;

  // emission request of the current state
  logic emit_req;
  res_t emit_res;
  logic emit_ok;

  // memories
  logic              tb_we;
  logic [POS_W-1:0]  tb_waddr;
  logic [7:0]        tb_rdata;
  slt_pkg::tbl_req_t treq;
  slt_pkg::tbl_rsp_t trsp;

  // decoded helpers
  logic       kw_hit;
  logic       fn_hit;
  logic       main_hit;
  logic [7:0] txt_fc;
  logic       op_pair;
  res_t       pair_res;
  logic       single_v;
  res_t       single_res;

  // a token start writes slot zero, later bytes append at the count
  assign tb_waddr = (state_q == S_START) ? '0 : cnt_q[POS_W-1:0];

  slt_tok_buf u_tok_buf (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .waddr_i (tb_waddr),
    .wdata_i (c_q),
    .raddr_i (j_q),
    .rdata_o (tb_rdata)
  );

  slt_name_tbl u_name_tbl (
    .clk_i (clk_i),
    .req_i (treq),
    .rsp_o (trsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign emit_ok    = !pend_v_q || !out_v_q || out_o.ready;

  assign kw_hit = word_is(kb_q, cnt_q, over_q, {"int", 24'h0}, 3) ||
                  word_is(kb_q, cnt_q, over_q, "return", 6) ||
                  word_is(kb_q, cnt_q, over_q, {"if", 32'h0}, 2) ||
                  word_is(kb_q, cnt_q, over_q, {"else", 16'h0}, 4) ||
                  word_is(kb_q, cnt_q, over_q, {"while", 8'h0}, 5) ||
                  word_is(kb_q, cnt_q, over_q, {"for", 24'h0}, 3);
  assign fn_hit = word_is(kb_q, cnt_q, over_q, {"printf"}, 6) ||
                  word_is(kb_q, cnt_q, over_q, {"scanf", 8'h0}, 5) ||
                  word_is(kb_q, cnt_q, over_q, {"getch", 8'h0}, 5) ||
                  word_is(kb_q, cnt_q, over_q, "clrscr", 6);
  // main only counts when '(' follows directly
  assign main_hit = hasnext_q && (c_q == "(") &&
                    word_is(kb_q, cnt_q, over_q, {"main", 16'h0}, 4);

  assign txt_fc = (cnt_q != '0) ? first_q : 8'd0;

  // two-byte operator completion and one-byte fallback
  always_comb begin
    op_pair    = 1'b0;
    pair_res   = mk(slt_pkg::CLS_ARITH_A, pop_q, 7'd2, 7'd0, 17'd0, 1'b0, 1'b0, 1'b0);
    single_v   = 1'b1;
    single_res = mk(slt_pkg::CLS_ARITH, pop_q, 7'd1, 7'd0, 17'd0, 1'b0, 1'b0, 1'b0);
    if (is_arith(pop_q) && c_q == "=") begin
      op_pair = 1'b1;
    end else if ((pop_q == "&" || pop_q == "|") && c_q == pop_q) begin
      op_pair      = 1'b1;
      pair_res.cls = slt_pkg::CLS_LOGIC;
    end else if ((pop_q == "!" || pop_q == "=" || pop_q == "<" || pop_q == ">") &&
                 c_q == "=") begin
      op_pair      = 1'b1;
      pair_res.cls = slt_pkg::CLS_REL;
    end
    if (is_arith(pop_q)) begin
      single_res.cls = slt_pkg::CLS_ARITH;
    end else if (pop_q == "!") begin
      single_res.cls = slt_pkg::CLS_LOGIC;
    end else if (pop_q == "=") begin
      single_res.cls = slt_pkg::CLS_ASSIGN;
    end else if (pop_q == "<" || pop_q == ">") begin
      single_res.cls = slt_pkg::CLS_REL;
    end else begin
      // lone & or | gives nothing
      single_v = 1'b0;
    end
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    c_d       = c_q;
    eot_d     = eot_q;
    cnt_d     = cnt_q;
    over_d    = over_q;
    first_d   = first_q;
    kb_d      = kb_q;
    pop_d     = pop_q;
    ec_d      = ec_q;
    nxt_d     = nxt_q;
    base_d    = base_q;
    eb_d      = eb_q;
    i_d       = i_q;
    j_d       = j_q;
    hasnext_d = hasnext_q;
    retfin_d  = retfin_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    out_d     = out_q;
    out_v_d   = out_v_q && !out_o.ready;
    emit_req  = 1'b0;
    emit_res  = mk(slt_pkg::CLS_STRING, 8'd0, 7'd0, 7'd0, 17'd0, 1'b0, 1'b0, 1'b0);
    tb_we     = 1'b0;

    treq.ent_we  = 1'b0;
    treq.byte_we = 1'b0;
    treq.widx    = ec_q[IDX_W-1:0];
    treq.wpos    = j_q;
    treq.wbyte   = tb_rdata;
    treq.wlen    = cnt_q;
    treq.waddr   = nxt_q;
    treq.ridx    = i_q;
    treq.rpos    = j_q;

    // configuration writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we_i) begin
      case (cfg_idx_i)
        slt_pkg::CFG_BASE: begin
          base_d = cfg_wdata_i;
          if (ec_q == '0) begin
            nxt_d = ADDR_W'(cfg_wdata_i);
          end
        end
        slt_pkg::CFG_EBYTE: begin
          eb_d = cfg_wdata_i[4:0];
        end
        default: begin
        end
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          c_d     = in_i.char_code;
          eot_d   = in_i.end_of_text;
          state_d = S_MODE;
        end
      end

      S_MODE: begin
        case (mode_q)
          M_WORD: begin
            if (is_alpha(c_q) || is_digit(c_q) || c_q == "_") begin
              tb_we   = 1'b1;
              state_d = S_EOT;
            end else begin
              mode_d    = M_IDLE;
              hasnext_d = 1'b1;
              retfin_d  = 1'b0;
              state_d   = S_KW;
            end
          end
          M_NUM: begin
            if (is_digit(c_q)) begin
              tb_we   = 1'b1;
              state_d = S_EOT;
            end else begin
              emit_req = 1'b1;
              emit_res = mk(slt_pkg::CLS_INT, txt_fc, 7'(cnt_q), 7'd0, 17'd0,
                            1'b0, 1'b0, over_q);
              if (emit_ok) begin
                mode_d  = M_IDLE;
                state_d = S_START;
              end
            end
          end
          M_STR: begin
            if (c_q == "\"") begin
              emit_req = 1'b1;
              emit_res = mk(slt_pkg::CLS_STRING, txt_fc, 7'(cnt_q), 7'd0, 17'd0,
                            1'b0, 1'b0, over_q);
              if (emit_ok) begin
                mode_d  = M_IDLE;
                state_d = S_EOT;
              end
            end else begin
              tb_we   = 1'b1;
              state_d = S_EOT;
            end
          end
          M_OP: begin
            emit_req = op_pair || single_v;
            emit_res = op_pair ? pair_res : single_res;
            if (!emit_req || emit_ok) begin
              mode_d  = M_IDLE;
              pop_d   = 8'd0;
              state_d = op_pair ? S_EOT : S_START;
            end
          end
          default: begin
            mode_d  = M_IDLE;
            state_d = S_START;
          end
        endcase
      end

      S_START: begin
        state_d = S_EOT;
        if (is_space(c_q)) begin
          state_d = S_EOT;
        end else if (c_q == "\"") begin
          mode_d = M_STR;
          cnt_d  = '0;
          over_d = 1'b0;
        end else if (is_alpha(c_q) || is_digit(c_q)) begin
          mode_d = is_alpha(c_q) ? M_WORD : M_NUM;
          cnt_d  = '0;
          over_d = 1'b0;
          // first byte goes to slot zero of the open token
          tb_we  = 1'b1;
        end else if (is_opch(c_q)) begin
          mode_d = M_OP;
          pop_d  = c_q;
        end else if (is_special(c_q)) begin
          emit_req = 1'b1;
          emit_res = mk(slt_pkg::CLS_SPECIAL, c_q, 7'd1, 7'd0, 17'd0, 1'b0, 1'b0, 1'b0);
          if (!emit_ok) begin
            state_d = S_START;
          end
        end
      end

      S_EOT: begin
        state_d = S_FIN;
        if (eot_q) begin
          case (mode_q)
            M_WORD: begin
              hasnext_d = 1'b0;
              retfin_d  = 1'b1;
              state_d   = S_KW;
            end
            M_NUM: begin
              emit_req = 1'b1;
              emit_res = mk(slt_pkg::CLS_INT, txt_fc, 7'(cnt_q), 7'd0, 17'd0,
                            1'b0, 1'b0, over_q);
            end
            M_STR: begin
              emit_req = 1'b1;
              emit_res = mk(slt_pkg::CLS_STRING, txt_fc, 7'(cnt_q), 7'd0, 17'd0,
                            1'b0, 1'b0, over_q);
            end
            M_OP: begin
              emit_req = single_v;
              emit_res = single_res;
            end
            default: begin
            end
          endcase
          if (emit_req && !emit_ok) begin
            state_d = S_EOT;
          end else begin
            mode_d = M_IDLE;
            pop_d  = 8'd0;
          end
        end
      end

      S_FIN: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (!out_v_q || out_o.ready) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end

      S_KW: begin
        if (kw_hit || fn_hit || main_hit) begin
          emit_req = 1'b1;
          emit_res = mk(kw_hit ? slt_pkg::CLS_KEYWORD :
                        (fn_hit ? slt_pkg::CLS_FUNC : slt_pkg::CLS_MAIN),
                        txt_fc, 7'(cnt_q), 7'd0, 17'd0, 1'b0, 1'b0, over_q);
          if (emit_ok) begin
            state_d = retfin_q ? S_FIN : S_START;
          end
        end else begin
          i_d     = '0;
          state_d = (ec_q == '0) ? S_NEW : S_LENRD;
        end
      end

      S_LENRD: begin
        state_d = S_LENCK;
      end

      S_LENCK: begin
        if (trsp.len == cnt_q) begin
          j_d     = '0;
          state_d = S_BRD;
        end else begin
          i_d     = i_q + IDX_W'(1);
          state_d = (EC_W'(i_q) + EC_W'(1) == ec_q) ? S_NEW : S_LENRD;
        end
      end

      S_BRD: begin
        state_d = S_BCK;
      end

      S_BCK: begin
        if (trsp.name_byte != tb_rdata) begin
          i_d     = i_q + IDX_W'(1);
          state_d = (EC_W'(i_q) + EC_W'(1) == ec_q) ? S_NEW : S_LENRD;
        end else if (CNT_W'(j_q) == cnt_q - CNT_W'(1)) begin
          // whole name matched, the entry address was read with the length
          emit_req = 1'b1;
          emit_res = mk(slt_pkg::CLS_IDENT, first_q, 7'(cnt_q), 7'(i_q), trsp.addr,
                        1'b0, 1'b0, over_q);
          if (emit_ok) begin
            state_d = retfin_q ? S_FIN : S_START;
          end
        end else begin
          j_d     = j_q + POS_W'(1);
          state_d = S_BRD;
        end
      end

      S_NEW: begin
        if (ec_q < EC_W'(slt_pkg::TABLE_DEPTH)) begin
          treq.ent_we = 1'b1;
          j_d         = '0;
          state_d     = S_CRD;
        end else begin
          emit_req = 1'b1;
          emit_res = mk(slt_pkg::CLS_IDENT, first_q, 7'(cnt_q), 7'd0, 17'd0,
                        1'b0, 1'b1, over_q);
          if (emit_ok) begin
            state_d = retfin_q ? S_FIN : S_START;
          end
        end
      end

      S_CRD: begin
        state_d = S_CWR;
      end

      S_CWR: begin
        treq.byte_we = 1'b1;
        if (CNT_W'(j_q) == cnt_q - CNT_W'(1)) begin
          state_d = S_NEMIT;
        end else begin
          j_d     = j_q + POS_W'(1);
          state_d = S_CRD;
        end
      end

      S_NEMIT: begin
        emit_req = 1'b1;
        emit_res = mk(slt_pkg::CLS_IDENT, first_q, 7'(cnt_q), 7'(ec_q), nxt_q,
                      1'b1, 1'b0, over_q);
        if (emit_ok) begin
          nxt_d   = ADDR_W'(nxt_q + ADDR_W'(eb_q));
          ec_d    = ec_q + EC_W'(1);
          state_d = retfin_q ? S_FIN : S_START;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // token byte append, saturating at the name limit
    if (tb_we) begin
      if (state_q == S_START) begin
        cnt_d   = CNT_W'(1);
        first_d = c_q;
        kb_d[0] = c_q;
      end else if (cnt_q < CNT_W'(slt_pkg::NAME_MAX)) begin
        cnt_d = cnt_q + CNT_W'(1);
        // first byte inside a string
        if (cnt_q == '0) begin
          first_d = c_q;
        end
        if (cnt_q < CNT_W'(KW_N)) begin
          kb_d[cnt_q[2:0]] = c_q;
        end
      end else begin
        tb_we  = 1'b0;
        over_d = 1'b1;
      end
    end

    // a new result pushes the held one out, not yet last
    if (emit_req && emit_ok) begin
      if (pend_v_q) begin
        out_d   = pend_q;
        out_v_d = 1'b1;
      end
      pend_d   = emit_res;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= M_IDLE;
      cnt_q    <= '0;
      over_q   <= 1'b0;
      pop_q    <= 8'd0;
      ec_q     <= '0;
      nxt_q    <= ADDR_W'(1000);
      base_q   <= 16'd1000;
      eb_q     <= 5'd4;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      over_q   <= over_d;
      pop_q    <= pop_d;
      ec_q     <= ec_d;
      nxt_q    <= nxt_d;
      base_q   <= base_d;
      eb_q     <= eb_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q       <= c_d;
    eot_q     <= eot_d;
    first_q   <= first_d;
    kb_q      <= kb_d;
    i_q       <= i_d;
    j_q       <= j_d;
    hasnext_q <= hasnext_d;
    retfin_q  <= retfin_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  assign out_o.valid          = out_v_q;
  assign out_o.token_class    = out_q.cls;
  assign out_o.first_char     = out_q.fc;
  assign out_o.token_length   = out_q.len;
  assign out_o.symbol_index   = out_q.idx;
  assign out_o.symbol_address = out_q.addr;
  assign out_o.is_new_symbol  = out_q.is_new;
  assign out_o.table_full     = out_q.full;
  assign out_o.name_truncated = out_q.trunc;
  assign out_o.last_of_run    = out_q.last;

`ifndef SYNTHESIS
  // nothing is held back once the block waits for the next character
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !pend_v_q)
    else $error("result left in holding register at idle");

  // an accepted character keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("ready while a character is in work");

  a_table_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ec_q <= EC_W'(slt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // a new entry moves the next address by one step
  a_addr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ec_q != $past(ec_q)) && !cfg_we_i |-> nxt_q == ADDR_W'($past(nxt_q) + ADDR_W'(eb_q)))
    else $error("next address out of step with entry count");
`endif

endmodule
